// File: rtl/core/wtrgb_pkg.sv
// ----------------------------------------------------------------------------
// wtrgb_pkg
// Shared constants, codes and helpers for the wavelength to RGB color mapper.
// ----------------------------------------------------------------------------
package wtrgb_pkg;

  localparam int GAMMA_INDEX_BITS_DEF = 10;

  localparam int W_W   = 14;  // wavelength field width
  localparam int NUM_W = 14;  // ramp numerator width
  localparam int RCP_W = 24;  // reciprocal width
  localparam int Q_W   = 17;  // Q1.16 fraction, with room for 1.0
  localparam int LVL_W = 8;

  localparam logic [Q_W-1:0] ONE_Q16 = 17'h1_0000;

  // band and fade edges, sixteenths of a nm
  localparam logic [W_W-1:0] W_380 = 14'd6080;
  localparam logic [W_W-1:0] W_440 = 14'd7040;
  localparam logic [W_W-1:0] W_490 = 14'd7840;
  localparam logic [W_W-1:0] W_510 = 14'd8160;
  localparam logic [W_W-1:0] W_580 = 14'd9280;
  localparam logic [W_W-1:0] W_645 = 14'd10320;
  localparam logic [W_W-1:0] W_781 = 14'd12496;
  localparam logic [W_W-1:0] W_420 = 14'd6720;
  localparam logic [W_W-1:0] W_701 = 14'd11216;
  localparam logic [W_W-1:0] W_780 = 14'd12480;

  localparam logic [NUM_W-1:0] FADE_LO_BASE = 14'd1920;
  localparam logic [NUM_W-1:0] FADE_HI_BASE = 14'd3840;
  localparam logic [NUM_W-1:0] FADE_SLOPE   = 14'd7;

  // divider span select codes
  localparam logic [2:0] DIV_960   = 3'd0;
  localparam logic [2:0] DIV_800   = 3'd1;
  localparam logic [2:0] DIV_320   = 3'd2;
  localparam logic [2:0] DIV_1120  = 3'd3;
  localparam logic [2:0] DIV_1040  = 3'd4;
  localparam logic [2:0] DIV_6400  = 3'd5;
  localparam logic [2:0] DIV_12800 = 3'd6;

  localparam logic [63:0] TWO32 = 64'h1_0000_0000;
  localparam logic [RCP_W-1:0] RCP_960   = 24'(TWO32 / 64'd960);
  localparam logic [RCP_W-1:0] RCP_800   = 24'(TWO32 / 64'd800);
  localparam logic [RCP_W-1:0] RCP_320   = 24'(TWO32 / 64'd320);
  localparam logic [RCP_W-1:0] RCP_1120  = 24'(TWO32 / 64'd1120);
  localparam logic [RCP_W-1:0] RCP_1040  = 24'(TWO32 / 64'd1040);
  localparam logic [RCP_W-1:0] RCP_6400  = 24'(TWO32 / 64'd6400);
  localparam logic [RCP_W-1:0] RCP_12800 = 24'(TWO32 / 64'd12800);

  // channel / factor modes
  localparam logic [1:0] CH_ZERO = 2'd0;
  localparam logic [1:0] CH_ONE  = 2'd1;
  localparam logic [1:0] CH_RAMP = 2'd2;

  // fallback color when every channel is dark
  localparam logic [LVL_W-1:0] FALLBACK_RED   = 8'd100;
  localparam logic [LVL_W-1:0] FALLBACK_GREEN = 8'd0;
  localparam logic [LVL_W-1:0] FALLBACK_BLUE  = 8'd101;

  // 255^5
  localparam logic [63:0] PEAK5 = 64'd1078203909375;

  function automatic logic [NUM_W-1:0] div_span(input logic [2:0] sel);
    logic [NUM_W-1:0] s;
    unique case (sel)
      DIV_960:   s = 14'd960;
      DIV_800:   s = 14'd800;
      DIV_320:   s = 14'd320;
      DIV_1120:  s = 14'd1120;
      DIV_1040:  s = 14'd1040;
      DIV_6400:  s = 14'd6400;
      DIV_12800: s = 14'd12800;
      default:   s = 14'd960;
    endcase
    return s;
  endfunction

  function automatic logic [RCP_W-1:0] div_recip(input logic [2:0] sel);
    logic [RCP_W-1:0] r;
    unique case (sel)
      DIV_960:   r = RCP_960;
      DIV_800:   r = RCP_800;
      DIV_320:   r = RCP_320;
      DIV_1120:  r = RCP_1120;
      DIV_1040:  r = RCP_1040;
      DIV_6400:  r = RCP_6400;
      DIV_12800: r = RCP_12800;
      default:   r = RCP_960;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/wavelength_to_rgb_color.sv
// ----------------------------------------------------------------------------
// wavelength_to_rgb_color
// Maps a wavelength in sixteenths of a nm to an 8-bit RGB color.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries in_wavelength_q4; output channel
// out_valid/out_ready carries out_red_level, out_green_level, out_blue_level.
// One result beat per input beat, in order.
// Throughput: one beat per cycle while out_ready keeps up. Stages:
// band decode, reciprocal multiply, divide correction, channel times
// fade factor, then eight gamma search stages whose last register drives
// the outputs.
// Each stage holds its own valid bit and advances whenever the stage after
// it is empty or moving, so bubbles close up and input keeps flowing while
// a result waits. When out_ready stays low the stages fill and in_ready
// drops once all twelve are full; nothing is dropped or repeated.
// Synchronous active-low reset empties the pipeline; the gamma table is a
// constant and needs no loading.
// ----------------------------------------------------------------------------
module wavelength_to_rgb_color #(
  parameter int GAMMA_INDEX_BITS = wtrgb_pkg::GAMMA_INDEX_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [wtrgb_pkg::W_W-1:0]       in_wavelength_q4,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [wtrgb_pkg::LVL_W-1:0]     out_red_level,
  output logic [wtrgb_pkg::LVL_W-1:0]     out_green_level,
  output logic [wtrgb_pkg::LVL_W-1:0]     out_blue_level
);

  localparam int NSTG  = 12;
  localparam int IDX_W = GAMMA_INDEX_BITS + 1;
  localparam int Q_W   = wtrgb_pkg::Q_W;
  localparam int NUM_W = wtrgb_pkg::NUM_W;

  // pipeline control
  logic [NSTG-1:0] v_r, vin, rdy, ld;

  assign vin = {v_r[NSTG-2:0], in_valid};

  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign ld = rdy & vin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (rdy[i]) begin
          v_r[i] <= vin[i];
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NSTG-1];

  // stage 0: band decode
  logic [wtrgb_pkg::W_W-1:0] w;
  logic [NUM_W-1:0]          cnum_nxt, fnum_nxt, cnum0_r, fnum0_r;
  logic [2:0]                csel_nxt, fsel_nxt, csel0_r, fsel0_r;
  logic [2:0][1:0]           cmode_nxt, cmode0_r, cmode1_r, cmode2_r;
  logic [1:0]                fmode_nxt, fmode0_r, fmode1_r, fmode2_r;

  assign w = in_wavelength_q4;

  // channel order: [0] red, [1] green, [2] blue
  always_comb begin
    cnum_nxt  = '0;
    csel_nxt  = wtrgb_pkg::DIV_960;
    cmode_nxt = {3{wtrgb_pkg::CH_ZERO}};
    if (w >= wtrgb_pkg::W_380 && w < wtrgb_pkg::W_440) begin
      cnum_nxt     = wtrgb_pkg::W_440 - w;
      csel_nxt     = wtrgb_pkg::DIV_960;
      cmode_nxt[0] = wtrgb_pkg::CH_RAMP;
      cmode_nxt[2] = wtrgb_pkg::CH_ONE;
    end else if (w >= wtrgb_pkg::W_440 && w < wtrgb_pkg::W_490) begin
      cnum_nxt     = w - wtrgb_pkg::W_440;
      csel_nxt     = wtrgb_pkg::DIV_800;
      cmode_nxt[1] = wtrgb_pkg::CH_RAMP;
      cmode_nxt[2] = wtrgb_pkg::CH_ONE;
    end else if (w >= wtrgb_pkg::W_490 && w < wtrgb_pkg::W_510) begin
      cnum_nxt     = wtrgb_pkg::W_510 - w;
      csel_nxt     = wtrgb_pkg::DIV_320;
      cmode_nxt[1] = wtrgb_pkg::CH_ONE;
      cmode_nxt[2] = wtrgb_pkg::CH_RAMP;
    end else if (w >= wtrgb_pkg::W_510 && w < wtrgb_pkg::W_580) begin
      cnum_nxt     = w - wtrgb_pkg::W_510;
      csel_nxt     = wtrgb_pkg::DIV_1120;
      cmode_nxt[0] = wtrgb_pkg::CH_RAMP;
      cmode_nxt[1] = wtrgb_pkg::CH_ONE;
    end else if (w >= wtrgb_pkg::W_580 && w < wtrgb_pkg::W_645) begin
      cnum_nxt     = wtrgb_pkg::W_645 - w;
      csel_nxt     = wtrgb_pkg::DIV_1040;
      cmode_nxt[0] = wtrgb_pkg::CH_ONE;
      cmode_nxt[1] = wtrgb_pkg::CH_RAMP;
    end else if (w >= wtrgb_pkg::W_645 && w < wtrgb_pkg::W_781) begin
      cmode_nxt[0] = wtrgb_pkg::CH_ONE;
    end
  end

  // fade factor; the upper ramp keeps its 780 nm anchor past 780 nm
  always_comb begin
    fnum_nxt  = '0;
    fsel_nxt  = wtrgb_pkg::DIV_6400;
    fmode_nxt = wtrgb_pkg::CH_ZERO;
    if (w >= wtrgb_pkg::W_380 && w < wtrgb_pkg::W_420) begin
      fnum_nxt  = wtrgb_pkg::FADE_LO_BASE
                + NUM_W'(wtrgb_pkg::FADE_SLOPE * (w - wtrgb_pkg::W_380));
      fsel_nxt  = wtrgb_pkg::DIV_6400;
      fmode_nxt = wtrgb_pkg::CH_RAMP;
    end else if (w >= wtrgb_pkg::W_420 && w < wtrgb_pkg::W_701) begin
      fmode_nxt = wtrgb_pkg::CH_ONE;
    end else if (w >= wtrgb_pkg::W_701 && w < wtrgb_pkg::W_781) begin
      if (w <= wtrgb_pkg::W_780) begin
        fnum_nxt = wtrgb_pkg::FADE_HI_BASE
                 + NUM_W'(wtrgb_pkg::FADE_SLOPE * (wtrgb_pkg::W_780 - w));
      end else begin
        fnum_nxt = wtrgb_pkg::FADE_HI_BASE
                 - NUM_W'(wtrgb_pkg::FADE_SLOPE * (w - wtrgb_pkg::W_780));
      end
      fsel_nxt  = wtrgb_pkg::DIV_12800;
      fmode_nxt = wtrgb_pkg::CH_RAMP;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      cnum0_r  <= cnum_nxt;
      csel0_r  <= csel_nxt;
      fnum0_r  <= fnum_nxt;
      fsel0_r  <= fsel_nxt;
      cmode0_r <= cmode_nxt;
      fmode0_r <= fmode_nxt;
    end
  end

  // stages 1-2: ramp dividers
  logic [Q_W-1:0] cq, fq;

  wtrgb_cdiv u_cdiv_chan (
    .clk     (clk),
    .en      (ld[2:1]),
    .num_in  (cnum0_r),
    .sel_in  (csel0_r),
    .quo_out (cq)
  );

  wtrgb_cdiv u_cdiv_fade (
    .clk     (clk),
    .en      (ld[2:1]),
    .num_in  (fnum0_r),
    .sel_in  (fsel0_r),
    .quo_out (fq)
  );

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      cmode1_r <= cmode0_r;
      fmode1_r <= fmode0_r;
    end
    if (ld[2]) begin
      cmode2_r <= cmode1_r;
      fmode2_r <= fmode1_r;
    end
  end

  // stage 3: channel times factor, gamma index
  logic [Q_W-1:0]            fval, pm;
  logic [2*Q_W-1:0]          pm_full;
  logic [2:0][Q_W-1:0]       p;
  logic [2:0][IDX_W-1:0]     idx_nxt, idx3_r;
  logic                      pur_nxt, pur3_r;

  always_comb begin
    unique case (fmode2_r)
      wtrgb_pkg::CH_ONE:  fval = wtrgb_pkg::ONE_Q16;
      wtrgb_pkg::CH_RAMP: fval = fq;
      default:            fval = '0;
    endcase
    pm_full = (2*Q_W)'(cq) * (2*Q_W)'(fval);
    pm      = pm_full[16 +: Q_W];
    for (int c = 0; c < 3; c++) begin
      unique case (cmode2_r[c])
        wtrgb_pkg::CH_ONE:  p[c] = fval;
        wtrgb_pkg::CH_RAMP: p[c] = pm;
        default:            p[c] = '0;
      endcase
      idx_nxt[c] = p[c][Q_W-1 -: IDX_W];
    end
    pur_nxt = (p[0] == '0) && (p[1] == '0) && (p[2] == '0);
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      idx3_r <= idx_nxt;
      pur3_r <= pur_nxt;
    end
  end

  // stages 4-11: gamma search
  wtrgb_gamma #(
    .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS)
  ) u_gamma_red (
    .clk         (clk),
    .en          (ld[11:4]),
    .idx_in      (idx3_r[0]),
    .fixed_in    (pur3_r),
    .fixed_level (wtrgb_pkg::FALLBACK_RED),
    .level_out   (out_red_level)
  );

  wtrgb_gamma #(
    .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS)
  ) u_gamma_green (
    .clk         (clk),
    .en          (ld[11:4]),
    .idx_in      (idx3_r[1]),
    .fixed_in    (pur3_r),
    .fixed_level (wtrgb_pkg::FALLBACK_GREEN),
    .level_out   (out_green_level)
  );

  wtrgb_gamma #(
    .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS)
  ) u_gamma_blue (
    .clk         (clk),
    .en          (ld[11:4]),
    .idx_in      (idx3_r[2]),
    .fixed_in    (pur3_r),
    .fixed_level (wtrgb_pkg::FALLBACK_BLUE),
    .level_out   (out_blue_level)
  );

endmodule

// File: rtl/core/wtrgb_cdiv.sv
// ----------------------------------------------------------------------------
// wtrgb_cdiv
// Two-stage divide of num * 65536 by one of a few constant spans: reciprocal
// multiply, then one compare-and-increment correction.
// ----------------------------------------------------------------------------
module wtrgb_cdiv (
  input  logic                            clk,
  input  logic [1:0]                      en,
  input  logic [wtrgb_pkg::NUM_W-1:0]     num_in,
  input  logic [2:0]                      sel_in,
  output logic [wtrgb_pkg::Q_W-1:0]       quo_out
);

  localparam int PROD_W = wtrgb_pkg::NUM_W + wtrgb_pkg::RCP_W;
  localparam int REM_W  = wtrgb_pkg::Q_W + wtrgb_pkg::NUM_W;

  logic [PROD_W-1:0]              prod;
  logic [wtrgb_pkg::Q_W-1:0]      q0_nxt, q0_r;
  logic [wtrgb_pkg::NUM_W-1:0]    num_r;
  logic [2:0]                     sel_r;
  logic [wtrgb_pkg::NUM_W-1:0]    span;
  logic [REM_W-1:0]               scaled, qs, rem;
  logic [wtrgb_pkg::Q_W-1:0]      quo_nxt, quo_r;

  always_comb begin
    prod   = PROD_W'(num_in) * PROD_W'(wtrgb_pkg::div_recip(sel_in));
    q0_nxt = prod[16 +: wtrgb_pkg::Q_W];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      q0_r  <= q0_nxt;
      num_r <= num_in;
      sel_r <= sel_in;
    end
  end

  // estimate is low by at most one
  always_comb begin
    span    = wtrgb_pkg::div_span(sel_r);
    scaled  = REM_W'({num_r, 16'h0000});
    qs      = REM_W'(q0_r) * REM_W'(span);
    rem     = scaled - qs;
    quo_nxt = q0_r + wtrgb_pkg::Q_W'(rem >= REM_W'(span));
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      quo_r <= quo_nxt;
    end
  end

  assign quo_out = quo_r;

endmodule

// File: rtl/core/wtrgb_gamma.sv
// ----------------------------------------------------------------------------
// wtrgb_gamma
// Eight-stage binary search of a threshold table giving
// floor(255 * x^0.8) for one channel, with a fixed-level override.
// ----------------------------------------------------------------------------
module wtrgb_gamma #(
  parameter int GAMMA_INDEX_BITS = wtrgb_pkg::GAMMA_INDEX_BITS_DEF
) (
  input  logic                            clk,
  input  logic [7:0]                      en,
  input  logic [GAMMA_INDEX_BITS:0]       idx_in,
  input  logic                            fixed_in,
  input  logic [wtrgb_pkg::LVL_W-1:0]     fixed_level,
  output logic [wtrgb_pkg::LVL_W-1:0]     level_out
);

  localparam int IDX_W = GAMMA_INDEX_BITS + 1;
  localparam int N     = 1 << GAMMA_INDEX_BITS;

  typedef logic [255:0][IDX_W-1:0] thr_tab_t;

  // entry o: smallest index i with (o/255)^5 <= (i/N)^4
  function automatic thr_tab_t build_thr();
    thr_tab_t     tab;
    logic [127:0] lhs, rhs, ii, oo;
    logic [15:0]  lo, hi, mid;
    tab = '0;
    for (int o = 1; o < 256; o++) begin
      oo  = 128'(o);
      lhs = (oo * oo * oo * oo * oo) << (4 * GAMMA_INDEX_BITS);
      lo  = '0;
      hi  = 16'(N);
      for (int s = 0; s < 16; s++) begin
        if (lo < hi) begin
          mid = (lo + hi) >> 1;
          ii  = 128'(mid);
          rhs = ii * ii * ii * ii * 128'(wtrgb_pkg::PEAK5);
          if (rhs >= lhs) begin
            hi = mid;
          end else begin
            lo = mid + 16'd1;
          end
        end
      end
      tab[o] = IDX_W'(hi);
    end
    return tab;
  endfunction

  localparam thr_tab_t THR = build_thr();

  logic [7:0][wtrgb_pkg::LVL_W-1:0] o_r;
  logic [6:0][IDX_W-1:0]            idx_r;
  logic [6:0]                       fix_r;

  for (genvar k = 0; k < 8; k++) begin : g_stage
    logic [wtrgb_pkg::LVL_W-1:0] o_in, cand, o_nxt;
    logic [IDX_W-1:0]            i_in;
    logic                        f_in;

    if (k == 0) begin : g_first
      assign o_in = '0;
      assign i_in = idx_in;
      assign f_in = fixed_in;
    end else begin : g_rest
      assign o_in = o_r[k-1];
      assign i_in = idx_r[k-1];
      assign f_in = fix_r[k-1];
    end

    assign cand  = o_in | (8'd1 << (7 - k));
    assign o_nxt = (THR[cand] <= i_in) ? cand : o_in;

    if (k < 7) begin : g_mid
      always_ff @(posedge clk) begin
        if (en[k]) begin
          o_r[k]   <= o_nxt;
          idx_r[k] <= i_in;
          fix_r[k] <= f_in;
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (en[k]) begin
          o_r[k] <= f_in ? fixed_level : o_nxt;
        end
      end
    end
  end

  assign level_out = o_r[7];

endmodule
